FILE: sv/rtpd_pkg.sv
// Shared types, constants and helpers for the RTP H.264 depacketizer.
`timescale 1ns / 1ps
`default_nettype none

package rtpd_pkg;

    localparam int CMD_FIFO_DEPTH = 4;

    localparam logic [4:0] NAL_STAP_A = 5'd24;
    localparam logic [4:0] NAL_FU_A   = 5'd28;

    // Position of the data byte that follows a start code
    localparam logic [2:0] SC_LEN = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_of_packet;
        logic       last_of_packet;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       unit_start;
        logic       run_last;
    } out_item_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SINGLE = 3'd1,
        PH_FU_HDR = 3'd2,
        PH_FU_DAT = 3'd3,
        PH_LEN_HI = 3'd4,
        PH_LEN_LO = 3'd5,
        PH_UNIT   = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_BYTE    = 2'd1,
        CMD_SC      = 2'd2,
        CMD_SC_BYTE = 2'd3
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] data;
    } cmd_t;

    // Annex-B start code 00 00 00 01
    function automatic logic [7:0] sc_byte(input logic [1:0] idx);
        logic [7:0] b;
        b = (idx == 2'd3) ? 8'h01 : 8'h00;
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: sv/rtpd_front.sv
// Front end: packet parser that turns payload bytes into output commands.
`timescale 1ns / 1ps
`default_nettype none

module rtpd_front
    import rtpd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_data,
    output logic          cmd_push,
    output cmd_t          cmd_data,
    input  wire logic     cmd_full
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  ind_reg, ind_next;
    logic [15:0] left_reg, left_next;
    logic [7:0]  lenhi_reg, lenhi_next;
    logic        in_acc;
    logic [7:0]  b;

    assign b        = in_data.in_byte;
    assign in_ready = !cmd_full;
    assign in_acc   = in_valid && in_ready;
    assign cmd_push = in_acc && (cmd_data.op != CMD_NONE);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        ind_next   = ind_reg;
        left_next  = left_reg;
        lenhi_next = lenhi_reg;
        if (in_acc)
        begin
            if (in_data.first_of_packet)
            begin
                if (b[4:0] == NAL_FU_A)
                begin
                    ind_next   = b[7:5];
                    phase_next = PH_FU_HDR;
                end
                else if (b[4:0] == NAL_STAP_A)
                    phase_next = PH_LEN_HI;
                else
                    phase_next = PH_SINGLE;
            end
            else
            begin
                case (phase_reg)
                    PH_SINGLE, PH_FU_DAT: phase_next = phase_reg;
                    PH_FU_HDR: phase_next = PH_FU_DAT;
                    PH_LEN_HI:
                    begin
                        lenhi_next = b;
                        phase_next = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        left_next  = {lenhi_reg, b};
                        phase_next = ({lenhi_reg, b} == 16'd0) ? PH_LEN_HI : PH_UNIT;
                    end
                    PH_UNIT:
                    begin
                        left_next = left_reg - 16'd1;
                        if (left_reg == 16'd1)
                            phase_next = PH_LEN_HI;
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
            if (in_data.last_of_packet)
                phase_next = PH_IDLE;
        end
    end

    // command out
    always_comb
    begin
        cmd_data.op   = CMD_NONE;
        cmd_data.data = b;
        if (in_data.first_of_packet)
        begin
            if (b[4:0] != NAL_FU_A && b[4:0] != NAL_STAP_A)
                cmd_data.op = CMD_SC_BYTE;
        end
        else
        begin
            case (phase_reg)
                PH_SINGLE, PH_FU_DAT, PH_UNIT: cmd_data.op = CMD_BYTE;
                PH_FU_HDR:
                begin
                    // rebuilt NAL header: F/NRI from indicator, type from FU header
                    cmd_data.data = {ind_reg, b[4:0]};
                    if (b[7])
                        cmd_data.op = CMD_SC_BYTE;
                end
                PH_LEN_LO: cmd_data.op = CMD_SC;
                default:   cmd_data.op = CMD_NONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            ind_reg   <= 3'd0;
            left_reg  <= 16'd0;
            lenhi_reg <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            ind_reg   <= ind_next;
            left_reg  <= left_next;
            lenhi_reg <= lenhi_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/rtpd_fifo.sv
// Small register queue of commands between parser and output sequencer.
`timescale 1ns / 1ps
`default_nettype none

module rtpd_fifo
    import rtpd_pkg::*;
#(
    parameter int DEPTH = CMD_FIFO_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      full,
    input  wire logic pop,
    output cmd_t      head,
    output logic      empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("command popped from empty queue");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("queue count did not advance on push");
`endif

endmodule

`default_nettype wire

FILE: sv/rtpd_back.sv
// Back end: expands commands into start code and stream bytes.
`timescale 1ns / 1ps
`default_nettype none

module rtpd_back
    import rtpd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t head,
    input  wire logic empty,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_item_t out_data
);

    logic [2:0] pos_reg, pos_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_data_reg, out_data_next;
    logic       load;
    logic [2:0] final_pos;

    assign load = !empty && (!out_valid_reg || out_ready);

    always_comb
    begin
        case (head.op)
            CMD_SC:      final_pos = SC_LEN - 3'd1;
            CMD_SC_BYTE: final_pos = SC_LEN;
            default:     final_pos = 3'd0;
        endcase
    end

    always_comb
    begin
        out_data_next.out_byte = head.data;
        if (head.op != CMD_BYTE && pos_reg < SC_LEN)
            out_data_next.out_byte = sc_byte(pos_reg[1:0]);
        out_data_next.unit_start = (head.op != CMD_BYTE) && (pos_reg == 3'd0);
        out_data_next.run_last   = (pos_reg == final_pos);
    end

    assign pop = load && (pos_reg == final_pos);

    always_comb
    begin
        pos_next = pos_reg;
        if (pop)
            pos_next = 3'd0;
        else if (load)
            pos_next = pos_reg + 3'd1;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= SC_LEN)
        else $error("sequencer position out of range");
    a_start_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.unit_start) |-> (out_data.out_byte == 8'h00 && !out_data.run_last))
        else $error("unit start not on leading start code byte");
    a_mid_cmd_held: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != 3'd0) |-> (!empty && head.op != CMD_BYTE && head.op != CMD_NONE))
        else $error("sequencer mid command without a start code command");
`endif

endmodule

`default_nettype wire

FILE: sv/rtp_h264_payload_depacketizer_top.sv
// RTP H.264 payload depacketizer: payload bytes in, Annex-B byte stream out.
// Usage:
//   in channel:  in_valid/in_ready with in_data (payload byte plus first and
//   last packet markers). One payload byte per transaction.
//   out channel: out_valid/out_ready with out_data (stream byte, unit_start on
//   the first start code byte of a NAL unit, run_last on the last byte caused
//   by one input byte). Input bytes that cause no output are simply consumed.
//   Path: an accepted input byte's command is written into the command queue,
//   and the output sequencer then loads its bytes into the output register.
//   Throughput: one byte per cycle for pass-through data while the receiver
//   is ready. A byte that opens a unit expands to four or five output bytes,
//   one per cycle, set by the output sequencer; the command queue (FIFO_DEPTH
//   entries) absorbs input meanwhile, and in_ready drops only while it is full.
//   Reset (rst_n low, asynchronous) returns the parser to idle, empties the
//   queue and clears out_valid. When the receiver stalls, the output register
//   holds its byte, the queue fills, and then the input is stalled.
`timescale 1ns / 1ps
`default_nettype none

module rtp_h264_payload_depacketizer_top
    import rtpd_pkg::*;
#(
    parameter int FIFO_DEPTH = CMD_FIFO_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    logic cmd_push;
    cmd_t cmd_data;
    logic cmd_full;
    logic cmd_pop;
    cmd_t cmd_head;
    logic cmd_empty;

    rtpd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .cmd_push (cmd_push),
        .cmd_data (cmd_data),
        .cmd_full (cmd_full)
    );

    rtpd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_data),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .head      (cmd_head),
        .empty     (cmd_empty)
    );

    rtpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (cmd_head),
        .empty     (cmd_empty),
        .pop       (cmd_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
